// ----- hdl/lpc_pkg.sv -----
`default_nettype none

package lpc_pkg;

  // Calibration store and output sizing
  localparam int TABLE_DEPTH = 65536;
  localparam int COORD_WIDTH = 24;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Input word layout
  localparam int DIST_MSB = 31;
  localparam int DIST_LSB = 13;
  localparam int RAW_D_W  = DIST_MSB - DIST_LSB + 1;
  localparam int INT_W    = 10;

  // Datapath widths
  localparam int DIST_W  = RAW_D_W + 2;        // 3 * d, unsigned
  localparam int PROD_W  = 32;                 // Q1.15 * Q1.15
  localparam int FRAC_D  = 15;                 // fraction bits dropped after scaling
  localparam int XF_W    = DIST_W + 1 + PROD_W; // dist * trig product
  localparam int DIR_W   = XF_W - FRAC_D;      // rounded x0 / y0
  localparam int Z_W     = DIST_W + 1 + 16;    // dist * sin_ele
  localparam int TERM_W  = 16 + DIR_W;         // coefficient * direction
  localparam int ACC_W   = TERM_W + 3;         // three terms plus translation
  localparam int FRAC_R  = 29;                 // fraction bits dropped after rotation
  localparam int TRANS_W = 23;

  localparam logic signed [XF_W-1:0] XF_HALF = XF_W'(1) <<< (FRAC_D - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (FRAC_R - 1);
  localparam logic signed [ACC_W-1:0] COORD_MAX = (ACC_W'(1) <<< (COORD_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] COORD_MIN = -COORD_MAX - ACC_W'(1);

  // Input item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int COUNT_W    = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd6;

  // Identity matrix at reset
  localparam logic [CFG_DATA_W-1:0] ROT_X_RST = 48'h0000_0000_4000;
  localparam logic [CFG_DATA_W-1:0] ROT_Y_RST = 48'h0000_4000_0000;
  localparam logic [CFG_DATA_W-1:0] ROT_Z_RST = 48'h4000_0000_0000;

  // One matrix row, c0 in the low bits
  typedef struct packed {
    logic signed [15:0] c2;
    logic signed [15:0] c1;
    logic signed [15:0] c0;
  } rot_row_t;

  // One calibration entry, cos_ele in the low bits
  typedef struct packed {
    logic signed [15:0] sin_azi;
    logic signed [15:0] cos_azi;
    logic signed [15:0] sin_ele;
    logic signed [15:0] cos_ele;
  } cal_entry_t;

endpackage

`default_nettype wire

// ----- hdl/lpc_if.sv -----
`default_nettype none

// Point input channel
interface lpc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] point_index;
  logic [31:0] raw_word;
  logic [63:0] cal_entry;

  modport source (output valid, mode, point_index, raw_word, cal_entry, input ready);
  modport sink   (input valid, mode, point_index, raw_word, cal_entry, output ready);
endinterface

// Result channel
interface lpc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   point_valid;
  logic signed [lpc_pkg::COORD_WIDTH-1:0] pos_x;
  logic signed [lpc_pkg::COORD_WIDTH-1:0] pos_y;
  logic signed [lpc_pkg::COORD_WIDTH-1:0] pos_z;
  logic [lpc_pkg::INT_W-1:0]              intensity;

  modport source (output valid, point_valid, pos_x, pos_y, pos_z, intensity, input ready);
  modport sink   (input valid, point_valid, pos_x, pos_y, pos_z, intensity, output ready);
endinterface

// Configuration write channel
interface lpc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpc_pkg::CFG_IDX_W-1:0]    index;
  logic [lpc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lpc_row.sv -----
`default_nettype none

// One row of the rigid transform: three products, sum with translation,
// round and saturate. Two register stages, both advancing on en_i.
module lpc_row (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  lpc_pkg::rot_row_t                      row_i,
  input  logic signed [lpc_pkg::TRANS_W-1:0]     trans_i,
  input  logic signed [lpc_pkg::DIR_W-1:0]       x0_i,
  input  logic signed [lpc_pkg::DIR_W-1:0]       y0_i,
  input  logic signed [lpc_pkg::Z_W-1:0]         z0_i,
  output logic signed [lpc_pkg::COORD_WIDTH-1:0] coord_o
);

  logic signed [lpc_pkg::TERM_W-1:0] tx_d, ty_d, tz_d;
  logic signed [lpc_pkg::TERM_W-1:0] tx_q, ty_q, tz_q;
  logic signed [lpc_pkg::TERM_W-1:0] z0_ext;
  logic signed [lpc_pkg::ACC_W-1:0]  trans_ext, acc_d, acc_q, shr, sat;

  // Coefficient products
  assign z0_ext = {{(lpc_pkg::TERM_W - lpc_pkg::Z_W){z0_i[lpc_pkg::Z_W-1]}}, z0_i};
  assign tx_d   = row_i.c0 * x0_i;
  assign ty_d   = row_i.c1 * y0_i;
  assign tz_d   = row_i.c2 * z0_ext;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
      tz_q <= tz_d;
    end
  end

  // Sum terms, translation and rounding half
  assign trans_ext = {{(lpc_pkg::ACC_W - lpc_pkg::TRANS_W){trans_i[lpc_pkg::TRANS_W-1]}},
                      trans_i} <<< lpc_pkg::FRAC_R;
  assign acc_d = {{(lpc_pkg::ACC_W - lpc_pkg::TERM_W){tx_q[lpc_pkg::TERM_W-1]}}, tx_q}
               + {{(lpc_pkg::ACC_W - lpc_pkg::TERM_W){ty_q[lpc_pkg::TERM_W-1]}}, ty_q}
               + {{(lpc_pkg::ACC_W - lpc_pkg::TERM_W){tz_q[lpc_pkg::TERM_W-1]}}, tz_q}
               + trans_ext + lpc_pkg::ACC_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  // Drop fraction (floor) and clamp to coordinate range
  assign shr = acc_q >>> lpc_pkg::FRAC_R;

  always_comb begin
    if (shr > lpc_pkg::COORD_MAX) begin
      sat = lpc_pkg::COORD_MAX;
    end else if (shr < lpc_pkg::COORD_MIN) begin
      sat = lpc_pkg::COORD_MIN;
    end else begin
      sat = shr;
    end
  end

  assign coord_o = sat[lpc_pkg::COORD_WIDTH-1:0];

endmodule

`default_nettype wire

// ----- hdl/lidar_point_to_cartesian.sv -----
`default_nettype none

// Lidar point to Cartesian converter. A load word (mode 0) writes one
// calibration entry into the on-chip table at point_index; a convert word
// (mode 1) yields one result: the stored direction scaled by the decoded
// distance, rotated by the configured Q1.14 matrix, translated and saturated,
// in half-millimetre units. The block takes one word every cycle while the
// output is not stalled; a convert result passes through the table read
// register, three direction-scaling stages, two matrix-row stages and the
// output register. The whole pipeline holds while the output register is
// full and not taken, so input ready drops only then. A load followed by a
// convert of the same index in the next cycle sees the new entry. The table
// has no reset: converting an index that was never loaded gives undefined
// coordinates. Configuration is taken at any cycle but must only be changed
// while no convert is in flight.
module lidar_point_to_cartesian (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpc_in_if.sink     point_i,
  lpc_cfg_if.sink    cfg_i,
  lpc_out_if.source  result_o
);

  localparam int NSTG = 6;

  // Configuration registers
  logic [lpc_pkg::CFG_DATA_W-1:0]    rot_x_q, rot_y_q, rot_z_q;
  logic [lpc_pkg::TRANS_W-1:0]       trans_x_q, trans_y_q, trans_z_q;
  logic [lpc_pkg::COUNT_W-1:0]       count_q;

  // Pipeline control and side data
  logic                              adv, in_acc;
  logic [NSTG-1:0]                   vld_q, ok_q;
  logic [lpc_pkg::INT_W-1:0]         int_q [NSTG];
  logic [lpc_pkg::RAW_D_W-1:0]       d_in;
  logic                              in_range, ok_d, cvt_d;

  // Datapath stages
  logic [63:0]                       cal_mem [lpc_pkg::TABLE_DEPTH];
  logic [lpc_pkg::ADDR_W-1:0]        addr;
  lpc_pkg::cal_entry_t               cal_q;
  logic [lpc_pkg::DIST_W-1:0]        dist_d, dist1_q, dist2_q;
  logic signed [lpc_pkg::PROD_W-1:0] pcs_d, pcc_d, pcs_q, pcc_q;
  logic signed [15:0]                se2_q;
  logic signed [lpc_pkg::DIST_W:0]   dist_s;
  logic signed [lpc_pkg::XF_W-1:0]   xf_d, yf_d, xf_q, yf_q, xr, yr;
  logic signed [lpc_pkg::Z_W-1:0]    z_d, z3_q, z4_q;
  logic signed [lpc_pkg::DIR_W-1:0]  x4_q, y4_q;
  logic signed [lpc_pkg::COORD_WIDTH-1:0] cx, cy, cz;

  // Output register
  logic                              out_valid_q, out_pv_q;
  logic signed [lpc_pkg::COORD_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic [lpc_pkg::INT_W-1:0]         out_int_q;

  // Advance everything unless a held result blocks the output
  assign adv           = ~out_valid_q | result_o.ready;
  assign point_i.ready = adv;
  assign in_acc        = point_i.valid & adv;
  assign cfg_i.ready   = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q   <= lpc_pkg::ROT_X_RST;
      rot_y_q   <= lpc_pkg::ROT_Y_RST;
      rot_z_q   <= lpc_pkg::ROT_Z_RST;
      trans_x_q <= '0;
      trans_y_q <= '0;
      trans_z_q <= '0;
      count_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lpc_pkg::REG_ROT_X:   rot_x_q   <= cfg_i.data;
        lpc_pkg::REG_ROT_Y:   rot_y_q   <= cfg_i.data;
        lpc_pkg::REG_ROT_Z:   rot_z_q   <= cfg_i.data;
        lpc_pkg::REG_TRANS_X: trans_x_q <= cfg_i.data[lpc_pkg::TRANS_W-1:0];
        lpc_pkg::REG_TRANS_Y: trans_y_q <= cfg_i.data[lpc_pkg::TRANS_W-1:0];
        lpc_pkg::REG_TRANS_Z: trans_z_q <= cfg_i.data[lpc_pkg::TRANS_W-1:0];
        lpc_pkg::REG_COUNT:   count_q   <= cfg_i.data[lpc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the incoming word
  assign d_in     = point_i.raw_word[lpc_pkg::DIST_MSB:lpc_pkg::DIST_LSB];
  assign dist_d   = {2'b00, d_in} + {1'b0, d_in, 1'b0};
  assign in_range = {1'b0, point_i.point_index} < 17'(lpc_pkg::TABLE_DEPTH);
  assign ok_d     = (d_in != '0) && in_range
                 && ({1'b0, point_i.point_index} < count_q);
  assign cvt_d    = in_acc && (point_i.mode == lpc_pkg::MODE_CONVERT);
  assign addr     = point_i.point_index[lpc_pkg::ADDR_W-1:0];

  // Calibration table: write on load, registered read on convert
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (point_i.mode == lpc_pkg::MODE_LOAD && in_range) begin
        cal_mem[addr] <= point_i.cal_entry;
      end
      if (point_i.mode == lpc_pkg::MODE_CONVERT) begin
        cal_q <= lpc_pkg::cal_entry_t'(cal_mem[addr]);
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], cvt_d};
    end
  end

  // Side data: validity flag and intensity
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q     <= {ok_q[NSTG-2:0], ok_d};
      int_q[0] <= point_i.raw_word[lpc_pkg::INT_W-1:0];
      for (int i = 1; i < NSTG; i++) begin
        int_q[i] <= int_q[i-1];
      end
    end
  end

  // Trig products
  assign pcs_d = cal_q.cos_ele * cal_q.sin_azi;
  assign pcc_d = cal_q.cos_ele * cal_q.cos_azi;

  // Scale by distance
  assign dist_s = {1'b0, dist2_q};
  assign xf_d   = dist_s * pcs_q;
  assign yf_d   = dist_s * pcc_q;
  assign z_d    = dist_s * se2_q;

  // Round off the direction fraction
  assign xr = xf_q + lpc_pkg::XF_HALF;
  assign yr = yf_q + lpc_pkg::XF_HALF;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist1_q <= dist_d;
      dist2_q <= dist1_q;
      pcs_q   <= pcs_d;
      pcc_q   <= pcc_d;
      se2_q   <= cal_q.sin_ele;
      xf_q    <= xf_d;
      yf_q    <= yf_d;
      z3_q    <= z_d;
      x4_q    <= xr[lpc_pkg::XF_W-1:lpc_pkg::FRAC_D];
      y4_q    <= yr[lpc_pkg::XF_W-1:lpc_pkg::FRAC_D];
      z4_q    <= z3_q;
    end
  end

  // Matrix rows
  lpc_row u_row_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .row_i   (lpc_pkg::rot_row_t'(rot_x_q)),
    .trans_i (trans_x_q),
    .x0_i    (x4_q),
    .y0_i    (y4_q),
    .z0_i    (z4_q),
    .coord_o (cx)
  );

  lpc_row u_row_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .row_i   (lpc_pkg::rot_row_t'(rot_y_q)),
    .trans_i (trans_y_q),
    .x0_i    (x4_q),
    .y0_i    (y4_q),
    .z0_i    (z4_q),
    .coord_o (cy)
  );

  lpc_row u_row_z (
    .clk_i   (clk_i),
    .en_i    (adv),
    .row_i   (lpc_pkg::rot_row_t'(rot_z_q)),
    .trans_i (trans_z_q),
    .x0_i    (x4_q),
    .y0_i    (y4_q),
    .z0_i    (z4_q),
    .coord_o (cz)
  );

  // Output register: hold while the word is not taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  // Zero the payload of an invalid point
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pv_q  <= ok_q[NSTG-1];
      out_x_q   <= ok_q[NSTG-1] ? cx : '0;
      out_y_q   <= ok_q[NSTG-1] ? cy : '0;
      out_z_q   <= ok_q[NSTG-1] ? cz : '0;
      out_int_q <= ok_q[NSTG-1] ? int_q[NSTG-1] : '0;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.point_valid = out_pv_q;
  assign result_o.pos_x       = out_x_q;
  assign result_o.pos_y       = out_y_q;
  assign result_o.pos_z       = out_z_q;
  assign result_o.intensity   = out_int_q;

endmodule

`default_nettype wire

// ----- hdl/lpc_checker.sv -----
`default_nettype none

module lpc_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_ready_i,
  input logic                                   cfg_valid_i,
  input logic                                   cfg_ready_i,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic                                   out_point_valid_i,
  input logic signed [lpc_pkg::COORD_WIDTH-1:0] out_pos_x_i,
  input logic signed [lpc_pkg::COORD_WIDTH-1:0] out_pos_y_i,
  input logic signed [lpc_pkg::COORD_WIDTH-1:0] out_pos_z_i,
  input logic [lpc_pkg::INT_W-1:0]              out_intensity_i
);

  // A stalled result word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_point_valid_i)
      && $stable(out_pos_x_i) && $stable(out_pos_y_i) && $stable(out_pos_z_i)
      && $stable(out_intensity_i))
    else $error("result word changed while stalled");

  // An invalid point carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_point_valid_i |-> out_pos_x_i == '0 && out_pos_y_i == '0
      && out_pos_z_i == '0 && out_intensity_i == '0)
    else $error("invalid point with nonzero fields");

  // Input is only held off by a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // Configuration writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write refused");

endmodule

bind lidar_point_to_cartesian lpc_checker u_lpc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (point_i.valid),
  .in_ready_i        (point_i.ready),
  .cfg_valid_i       (cfg_i.valid),
  .cfg_ready_i       (cfg_i.ready),
  .out_valid_i       (result_o.valid),
  .out_ready_i       (result_o.ready),
  .out_point_valid_i (result_o.point_valid),
  .out_pos_x_i       (result_o.pos_x),
  .out_pos_y_i       (result_o.pos_y),
  .out_pos_z_i       (result_o.pos_z),
  .out_intensity_i   (result_o.intensity)
);

`default_nettype wire
